/* hdl/gamma_curve_entry_generator_assert.svh */
// assertion macros for the gamma curve entry generator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef GAMMA_CURVE_ENTRY_GENERATOR_ASSERT_SVH
`define GAMMA_CURVE_ENTRY_GENERATOR_ASSERT_SVH

// condition must hold in the same cycle
`define GCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the following cycle
`define GCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gce_pkg.sv */
// shared types and constants for the gamma curve entry generator
// no dependencies
`default_nettype none

package gce_pkg;

    // field and register widths
    localparam int IDX_W     = 12;
    localparam int ENT_W     = 13;
    localparam int GAMMA_W   = 16;
    localparam int VAL_W     = 16;
    localparam int CFG_W     = 16;

    // log2 datapath
    localparam int MANT_W     = 31;
    localparam int FRAC_W     = 32;
    localparam int POS_W      = 4;
    localparam int LOG_STAGES = FRAC_W;

    // exponent division
    localparam int NUM_W      = 50;
    localparam int QUOT_W     = 38;
    localparam int DIV_STAGES = QUOT_W;

    // exp2 series
    localparam int U_W        = 30;
    localparam int TERM_W     = 31;
    localparam int SUM_W      = 32;
    localparam int K_W        = 5;
    localparam int EXP_TERMS  = 14;
    localparam int PROD_W     = 48;

    // constants of the curve
    localparam logic [31:0]        LN2_Q32      = 32'd2977044472;
    localparam logic [GAMMA_W-1:0] GAMMA_LOW    = 16'd4915;
    localparam logic [GAMMA_W-1:0] GAMMA_HIGH   = 16'd32768;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET  = 16'd16384;
    localparam logic [ENT_W-1:0]   ENT_MIN      = 13'd2;
    localparam logic [ENT_W-1:0]   ENT_RESET    = 13'd256;
    localparam logic [VAL_W-1:0]   FULL_SCALE   = 16'hFFFF;
    localparam logic [5:0]         K_LIMIT      = 6'd17;
    localparam int                 MAX_ENTRIES_DEF = 4096;

    // register indexes
    localparam logic CFG_GAMMA   = 1'b0;
    localparam logic CFG_ENTRIES = 1'b1;

    // how a request is finished
    typedef enum logic [1:0] {
        KIND_CALC,
        KIND_ZERO,
        KIND_FULL
    } kind_t;

    // log2 pipeline payload, lane a is the last index, lane b the request index
    typedef struct packed {
        kind_t              kind;
        logic [MANT_W-1:0]  ma;
        logic [MANT_W-1:0]  mb;
        logic [FRAC_W-1:0]  fa;
        logic [FRAC_W-1:0]  fb;
        logic [POS_W-1:0]   pa;
        logic [POS_W-1:0]   pb;
    } log_data_t;

    // divider pipeline payload
    typedef struct packed {
        kind_t              kind;
        logic [GAMMA_W-1:0] rem;
        logic [QUOT_W-1:0]  low;
        logic [QUOT_W-1:0]  quot;
    } div_data_t;

    // series pipeline payload
    typedef struct packed {
        kind_t              kind;
        logic               fz;
        logic [K_W-1:0]     k;
        logic [U_W-1:0]     u;
        logic [TERM_W-1:0]  term;
        logic [SUM_W-1:0]   sum;
    } exp_data_t;

endpackage

`default_nettype wire

/* hdl/gce_log_cell.sv */
// one squaring step of the fixed-point log2, two lanes side by side
// depends on gce_pkg
`default_nettype none

module gce_log_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  gce_pkg::log_data_t      in_data,
    output logic                    out_valid,
    output gce_pkg::log_data_t      out_data
);

    logic                           valid_reg;
    gce_pkg::log_data_t             data_reg;
    gce_pkg::log_data_t             data_next;
    logic [2*gce_pkg::MANT_W-1:0]   sqa;
    logic [2*gce_pkg::MANT_W-1:0]   sqb;
    logic [31:0]                    ta;
    logic [31:0]                    tb;

    // square both mantissas, renormalize and emit one fraction bit each
    always_comb
    begin
        sqa = (2*gce_pkg::MANT_W)'(in_data.ma) * (2*gce_pkg::MANT_W)'(in_data.ma);
        sqb = (2*gce_pkg::MANT_W)'(in_data.mb) * (2*gce_pkg::MANT_W)'(in_data.mb);
        ta  = sqa[61:30];
        tb  = sqb[61:30];
        data_next      = in_data;
        data_next.ma   = ta[31] ? ta[31:1] : ta[30:0];
        data_next.mb   = tb[31] ? tb[31:1] : tb[30:0];
        data_next.fa   = {in_data.fa[gce_pkg::FRAC_W-2:0], ta[31]};
        data_next.fb   = {in_data.fb[gce_pkg::FRAC_W-2:0], tb[31]};
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hdl/gce_div_cell.sv */
// one restoring step of the exponent division by gamma
// depends on gce_pkg
`default_nettype none

module gce_div_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic [gce_pkg::GAMMA_W-1:0]   gamma,
    input  wire logic                          in_valid,
    input  gce_pkg::div_data_t                 in_data,
    output logic                               out_valid,
    output gce_pkg::div_data_t                 out_data
);

    logic                           valid_reg;
    gce_pkg::div_data_t             data_reg;
    gce_pkg::div_data_t             data_next;
    logic [gce_pkg::GAMMA_W:0]      r2;
    logic [gce_pkg::GAMMA_W:0]      diff;
    logic                           ge;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        r2   = {in_data.rem, in_data.low[gce_pkg::QUOT_W-1]};
        diff = r2 - {1'b0, gamma};
        ge   = (r2 >= {1'b0, gamma});
        data_next      = in_data;
        data_next.rem  = ge ? diff[gce_pkg::GAMMA_W-1:0] : r2[gce_pkg::GAMMA_W-1:0];
        data_next.low  = {in_data.low[gce_pkg::QUOT_W-2:0], 1'b0};
        data_next.quot = {in_data.quot[gce_pkg::QUOT_W-2:0], ge};
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hdl/gce_exp_cell.sv */
// one term of the exp2 series: multiply by u, then divide by the term number
// depends on gce_pkg
`default_nettype none

module gce_exp_cell #(
    parameter int TERM_N = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  gce_pkg::exp_data_t      in_data,
    output logic                    out_valid,
    output gce_pkg::exp_data_t      out_data
);

    // exact reciprocal for dividends below 2^30
    localparam int          SHIFT = $clog2(TERM_N);
    localparam logic [31:0] RECIP =
        32'(((64'd1 << (30 + SHIFT)) + 64'(TERM_N) - 64'd1) / 64'(TERM_N));

    logic                   mid_valid_reg;
    gce_pkg::exp_data_t     mid_reg;
    gce_pkg::exp_data_t     mid_next;
    logic                   valid_reg;
    gce_pkg::exp_data_t     data_reg;
    gce_pkg::exp_data_t     data_next;
    logic [60:0]            prod_a;
    logic [61:0]            prod_b;
    logic [29:0]            quo;

    // first half: term times u, the term field carries the product
    always_comb
    begin
        prod_a        = 61'(in_data.term) * 61'(in_data.u);
        mid_next      = in_data;
        mid_next.term = gce_pkg::TERM_W'(prod_a[60:30]);
    end

    // second half: divide by the term number and accumulate
    always_comb
    begin
        prod_b         = 62'(mid_reg.term[29:0]) * 62'(RECIP);
        quo            = 30'(prod_b >> (30 + SHIFT));
        data_next      = mid_reg;
        data_next.term = gce_pkg::TERM_W'(quo);
        data_next.sum  = mid_reg.sum + gce_pkg::SUM_W'(quo);
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= in_valid;
            valid_reg     <= mid_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg  <= mid_next;
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hdl/gamma_curve_entry_generator.sv */
// Gamma curve entry generator: one request per clock while the output buffer has room, each answered
// after passing the input register, 32 log2 squaring cells, 38 divider cells, 14 two-stage
// series cells, operand and product registers and the output buffer. A two-entry output buffer
// keeps the pipeline moving while a result waits; the whole chain holds only when both
// entries are occupied. Configuration writes are taken every cycle and must only be made
// while no request is in flight.
// depends on gce_pkg, gce_log_cell, gce_div_cell, gce_exp_cell
`default_nettype none

module gamma_curve_entry_generator #(
    parameter int MAX_ENTRIES = gce_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [gce_pkg::IDX_W-1:0]     entry_index,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gce_pkg::VAL_W-1:0]          curve_value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [gce_pkg::CFG_W-1:0]     cfg_data
);

    // configuration
    logic [gce_pkg::GAMMA_W-1:0]    gamma_reg;
    logic [gce_pkg::ENT_W-1:0]      entries_reg;
    logic [gce_pkg::GAMMA_W-1:0]    gamma_next;
    logic [gce_pkg::ENT_W-1:0]      entries_next;

    // pipeline control
    logic                           en;
    logic [1:0]                     cnt_reg;
    logic [1:0]                     cnt_next;

    // front end
    logic [gce_pkg::ENT_W-1:0]      last;
    logic [gce_pkg::ENT_W-1:0]      idx_ext;
    logic [gce_pkg::POS_W-1:0]      pos_a;
    logic [gce_pkg::POS_W-1:0]      pos_b;
    gce_pkg::log_data_t             front_next;
    gce_pkg::log_data_t             front_reg;
    logic                           front_valid_reg;

    // chains
    gce_pkg::log_data_t             log_d [gce_pkg::LOG_STAGES+1];
    logic                           log_v [gce_pkg::LOG_STAGES+1];
    gce_pkg::div_data_t             div_d [gce_pkg::DIV_STAGES+1];
    logic                           div_v [gce_pkg::DIV_STAGES+1];
    gce_pkg::exp_data_t             exp_d [gce_pkg::EXP_TERMS+1];
    logic                           exp_v [gce_pkg::EXP_TERMS+1];

    // division setup
    logic [35:0]                    la;
    logic [35:0]                    lb;
    logic [35:0]                    dlog;
    logic [gce_pkg::NUM_W-1:0]      num;
    gce_pkg::div_data_t             div_next;
    gce_pkg::div_data_t             div_reg;
    logic                           div_valid_reg;

    // series setup
    logic [5:0]                     k_full;
    logic [31:0]                    frac;
    logic [31:0]                    gfrac;
    logic [63:0]                    uprod;
    gce_pkg::exp_data_t             exp_next;
    gce_pkg::exp_data_t             exp_reg;
    logic                           exp_valid_reg;

    // final product
    logic [gce_pkg::SUM_W-1:0]      s_val;
    logic [gce_pkg::PROD_W-1:0]     prod_next;
    logic [gce_pkg::PROD_W-1:0]     fin_prod_reg;
    logic [gce_pkg::K_W-1:0]        fin_k_reg;
    gce_pkg::kind_t                 fin_kind_reg;
    logic                           fin_valid_reg;
    logic [gce_pkg::PROD_W:0]       rnd;
    logic [gce_pkg::PROD_W:0]       shv;
    logic [gce_pkg::VAL_W-1:0]      result;

    // output buffer
    logic [gce_pkg::VAL_W-1:0]      buf0_reg;
    logic [gce_pkg::VAL_W-1:0]      buf1_reg;
    logic                           push;
    logic                           pop;

    // position of the leading one
    function automatic logic [gce_pkg::POS_W-1:0] lead_pos(input logic [gce_pkg::ENT_W-1:0] v);
        logic [gce_pkg::POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < gce_pkg::ENT_W; i++)
        begin
            if (v[i])
            begin
                p = gce_pkg::POS_W'(i);
            end
        end
        return p;
    endfunction

    // mantissa in [2^30, 2^31)
    function automatic logic [gce_pkg::MANT_W-1:0] norm(input logic [gce_pkg::ENT_W-1:0] v,
                                                       input logic [gce_pkg::POS_W-1:0] p);
        logic [gce_pkg::MANT_W-1:0] m;
        m = gce_pkg::MANT_W'(v);
        return m << (5'd30 - {1'b0, p});
    endfunction

    // configuration writes with saturation
    assign cfg_ready = 1'b1;

    always_comb
    begin
        priority if (cfg_data < gce_pkg::GAMMA_LOW)
        begin
            gamma_next = gce_pkg::GAMMA_LOW;
        end
        else if (cfg_data > gce_pkg::GAMMA_HIGH)
        begin
            gamma_next = gce_pkg::GAMMA_HIGH;
        end
        else
        begin
            gamma_next = cfg_data;
        end

        priority if (cfg_data[gce_pkg::ENT_W-1:0] < gce_pkg::ENT_MIN)
        begin
            entries_next = gce_pkg::ENT_MIN;
        end
        else if (32'(cfg_data[gce_pkg::ENT_W-1:0]) > 32'(MAX_ENTRIES))
        begin
            entries_next = gce_pkg::ENT_W'(MAX_ENTRIES);
        end
        else
        begin
            entries_next = cfg_data[gce_pkg::ENT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg   <= gce_pkg::GAMMA_RESET;
            entries_reg <= gce_pkg::ENT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gce_pkg::CFG_GAMMA:   gamma_reg   <= gamma_next;
                gce_pkg::CFG_ENTRIES: entries_reg <= entries_next;
                default:              gamma_reg   <= gamma_reg;
            endcase
        end
    end

    // whole chain advances while the output buffer has room
    assign en       = (cnt_reg != 2'd2);
    assign in_ready = en;

    // classify the request and normalize both operands
    always_comb
    begin
        last    = entries_reg - 13'd1;
        idx_ext = {1'b0, entry_index};
        pos_a   = lead_pos(last);
        pos_b   = lead_pos(idx_ext);
        front_next.ma = norm(last, pos_a);
        front_next.mb = norm(idx_ext, pos_b);
        front_next.fa = '0;
        front_next.fb = '0;
        front_next.pa = pos_a;
        front_next.pb = pos_b;
        priority if (idx_ext >= last)
        begin
            front_next.kind = gce_pkg::KIND_FULL;
        end
        else if (entry_index == '0)
        begin
            front_next.kind = gce_pkg::KIND_ZERO;
        end
        else
        begin
            front_next.kind = gce_pkg::KIND_CALC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg <= front_next;
        end
    end

    assign log_d[0] = front_reg;
    assign log_v[0] = front_valid_reg;

    // log2 chain, one fraction bit per cell
    for (genvar i = 0; i < gce_pkg::LOG_STAGES; i++)
    begin : g_log
        gce_log_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (log_v[i]),
            .in_data   (log_d[i]),
            .out_valid (log_v[i+1]),
            .out_data  (log_d[i+1])
        );
    end

    // log difference scaled by 2^14 plus half of gamma for rounding
    always_comb
    begin
        la   = {log_d[gce_pkg::LOG_STAGES].pa, log_d[gce_pkg::LOG_STAGES].fa};
        lb   = {log_d[gce_pkg::LOG_STAGES].pb, log_d[gce_pkg::LOG_STAGES].fb};
        dlog = (la > lb) ? (la - lb) : '0;
        num  = {dlog, 14'b0} + gce_pkg::NUM_W'(gamma_reg >> 1);
        div_next.kind = log_d[gce_pkg::LOG_STAGES].kind;
        div_next.rem  = gce_pkg::GAMMA_W'(num[gce_pkg::NUM_W-1:gce_pkg::QUOT_W]);
        div_next.low  = num[gce_pkg::QUOT_W-1:0];
        div_next.quot = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            div_valid_reg <= log_v[gce_pkg::LOG_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign div_d[0] = div_reg;
    assign div_v[0] = div_valid_reg;

    // divider chain, one quotient bit per cell
    for (genvar i = 0; i < gce_pkg::DIV_STAGES; i++)
    begin : g_div
        gce_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .gamma     (gamma_reg),
            .in_valid  (div_v[i]),
            .in_data   (div_d[i]),
            .out_valid (div_v[i+1]),
            .out_data  (div_d[i+1])
        );
    end

    // split exponent, u = (1 - f) * ln2
    always_comb
    begin
        k_full = div_d[gce_pkg::DIV_STAGES].quot[gce_pkg::QUOT_W-1:32];
        frac   = div_d[gce_pkg::DIV_STAGES].quot[31:0];
        gfrac  = ~frac + 32'd1;
        uprod  = 64'(gfrac) * 64'(gce_pkg::LN2_Q32);
        exp_next.kind = div_d[gce_pkg::DIV_STAGES].kind;
        if ((div_d[gce_pkg::DIV_STAGES].kind == gce_pkg::KIND_CALC) && (k_full >= gce_pkg::K_LIMIT))
        begin
            // curve value below half an lsb
            exp_next.kind = gce_pkg::KIND_ZERO;
        end
        exp_next.fz   = (frac == '0);
        exp_next.k    = k_full[gce_pkg::K_W-1:0];
        exp_next.u    = uprod[63:34];
        exp_next.term = gce_pkg::TERM_W'(32'h4000_0000);
        exp_next.sum  = 32'h4000_0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            exp_valid_reg <= div_v[gce_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            exp_reg <= exp_next;
        end
    end

    assign exp_d[0] = exp_reg;
    assign exp_v[0] = exp_valid_reg;

    // series chain, one taylor term per cell
    for (genvar i = 0; i < gce_pkg::EXP_TERMS; i++)
    begin : g_exp
        gce_exp_cell #(
            .TERM_N (i + 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (exp_v[i]),
            .in_data   (exp_d[i]),
            .out_valid (exp_v[i+1]),
            .out_data  (exp_d[i+1])
        );
    end

    // 65535 * s without a multiplier
    always_comb
    begin
        s_val     = exp_d[gce_pkg::EXP_TERMS].fz ? 32'h8000_0000 : exp_d[gce_pkg::EXP_TERMS].sum;
        prod_next = (gce_pkg::PROD_W'(s_val) << 16) - gce_pkg::PROD_W'(s_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_valid_reg <= exp_v[gce_pkg::EXP_TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_prod_reg <= prod_next;
            fin_k_reg    <= exp_d[gce_pkg::EXP_TERMS].k;
            fin_kind_reg <= exp_d[gce_pkg::EXP_TERMS].kind;
        end
    end

    // round half up at 2^(31+k) and clamp
    always_comb
    begin
        rnd = {1'b0, fin_prod_reg} + ((gce_pkg::PROD_W+1)'(1) << (6'd30 + {1'b0, fin_k_reg}));
        shv = rnd >> (6'd31 + {1'b0, fin_k_reg});
        unique case (fin_kind_reg)
            gce_pkg::KIND_CALC:
            begin
                if (shv > (gce_pkg::PROD_W+1)'(gce_pkg::FULL_SCALE))
                begin
                    result = gce_pkg::FULL_SCALE;
                end
                else
                begin
                    result = shv[gce_pkg::VAL_W-1:0];
                end
            end
            gce_pkg::KIND_ZERO: result = '0;
            gce_pkg::KIND_FULL: result = gce_pkg::FULL_SCALE;
            default:            result = '0;
        endcase
    end

    // two-entry output buffer
    assign push      = en && fin_valid_reg;
    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign curve_value = buf0_reg;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    buf0_reg <= result;
                end
                else
                begin
                    buf1_reg <= result;
                end
            end
            2'b01:
            begin
                buf0_reg <= buf1_reg;
            end
            2'b11:
            begin
                buf0_reg <= result;
            end
            default:
            begin
                buf0_reg <= buf0_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/gce_checker.sv */
// port-level checks for the gamma curve entry generator, bound to the top level
// depends on gamma_curve_entry_generator_assert.svh
`default_nettype none

`include "gamma_curve_entry_generator_assert.svh"

module gce_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] curve_value
);

    // a stalled result stays put
    `GCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(curve_value), "result changed while stalled")

    // input only stalls when results are waiting
    `GCE_ASSERT_NOW(a_stall_needs_result, !in_ready, out_valid, "input stalled with no result pending")

    // one taken result frees the input again
    `GCE_ASSERT_NEXT(a_stall_clears, !in_ready && out_ready, in_ready, "input still stalled after a result was taken")

endmodule

bind gamma_curve_entry_generator gce_checker u_gce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_value (curve_value)
);

`default_nettype wire

/* bench/gamma_curve_entry_generator_chk.sv */
// checker for the gamma curve entry generator: predicts each curve value and compares
// depends on gce_pkg and on the channels of the block, which it only watches
`default_nettype none

module gamma_curve_entry_generator_chk (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_ready,
    input  wire logic [gce_pkg::IDX_W-1:0] entry_index,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire logic [gce_pkg::VAL_W-1:0] curve_value,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic                      cfg_index,
    input  wire logic [gce_pkg::CFG_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending_count,
    output int                             value_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [gce_pkg::GAMMA_W-1:0] gamma_q14;
    logic [gce_pkg::ENT_W-1:0]   entry_total;
    logic [gce_pkg::VAL_W-1:0]   value_queue[$];

    // log2 of an integer, Q.32, by repeated squaring of the mantissa
    function automatic logic [63:0] log2_q32(input logic [31:0] v);
        logic [31:0] p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 0;
        frac = 0;
        if (v == 0)
        begin
            v = 1;
        end
        while (p < 31 && (v >> (p + 1)) != 0)
        begin
            p++;
        end
        m = ({32'b0, v} << 30) >> p;
        for (int b = 31; b >= 0; b--)
        begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                frac[b] = 1'b1;
            end
        end
        return ({32'b0, p} << 32) | frac;
    endfunction

    // 2^(1-f) in Q.30 from a truncated series of e^u
    function automatic logic [63:0] pow2_one_minus(input logic [31:0] f);
        logic [63:0] g;
        logic [63:0] u;
        logic [63:0] sum;
        logic [63:0] term;
        if (f == 0)
        begin
            return 64'd1 << 31;
        end
        g = (64'd1 << 32) - {32'b0, f};
        u = (g * {32'b0, gce_pkg::LN2_Q32}) >> 34;
        sum = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 30; n++)
        begin
            term = ((term * u) >> 30) / n;
            if (term == 0)
            begin
                break;
            end
            sum += term;
        end
        return sum;
    endfunction

    // corrected level for one table position under the current registers
    function automatic logic [gce_pkg::VAL_W-1:0] corrected_level(
        input logic [gce_pkg::IDX_W-1:0] idx);
        logic [31:0] last;
        logic [63:0] la;
        logic [63:0] lb;
        logic [63:0] d;
        logic [63:0] e;
        logic [63:0] k;
        logic [63:0] s;
        logic [63:0] r;
        last = {19'b0, entry_total} - 1;
        if ({20'b0, idx} >= last)
        begin
            return gce_pkg::FULL_SCALE;
        end
        if (idx == 0)
        begin
            return '0;
        end
        la = log2_q32(last);
        lb = log2_q32({20'b0, idx});
        d = (la > lb) ? la - lb : 64'd0;
        e = (d * 64'd16384 + {48'b0, gamma_q14} / 2) / {48'b0, gamma_q14};
        k = e >> 32;
        if (k >= 17)
        begin
            return '0;
        end
        s = pow2_one_minus(e[31:0]);
        r = (64'd65535 * s + (64'd1 << (30 + k))) >> (31 + k);
        if (r > 64'd65535)
        begin
            r = 64'd65535;
        end
        return r[gce_pkg::VAL_W-1:0];
    endfunction

    assign pending_count = value_queue.size();

    // track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_q14   <= gce_pkg::GAMMA_RESET;
            entry_total <= gce_pkg::ENT_RESET;
            fail_count  <= 0;
            value_count <= 0;
            value_queue.delete();
        end
        else
        begin
            // register write, saturated into the legal range
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gce_pkg::CFG_GAMMA)
                begin
                    if (cfg_data < gce_pkg::GAMMA_LOW)
                        gamma_q14 <= gce_pkg::GAMMA_LOW;
                    else if (cfg_data > gce_pkg::GAMMA_HIGH)
                        gamma_q14 <= gce_pkg::GAMMA_HIGH;
                    else
                        gamma_q14 <= cfg_data;
                end
                else
                begin
                    if (cfg_data[gce_pkg::ENT_W-1:0] < gce_pkg::ENT_MIN)
                        entry_total <= gce_pkg::ENT_MIN;
                    else if (cfg_data[gce_pkg::ENT_W-1:0] > gce_pkg::MAX_ENTRIES_DEF)
                        entry_total <= gce_pkg::ENT_W'(gce_pkg::MAX_ENTRIES_DEF);
                    else
                        entry_total <= cfg_data[gce_pkg::ENT_W-1:0];
                end
            end
            // accepted request
            if (in_valid && in_ready)
            begin
                value_queue.push_back(corrected_level(entry_index));
            end
            // accepted result
            if (out_valid && out_ready)
            begin
                value_count <= value_count + 1;
                if (value_queue.size() == 0)
                begin
                    $error("curve_value unexpected result %0d", curve_value);
                    fail_count <= fail_count + 1;
                end
                else if (value_queue[0] !== curve_value)
                begin
                    $error("curve_value expected %0d actual %0d", value_queue[0], curve_value);
                    fail_count <= fail_count + 1;
                    void'(value_queue.pop_front());
                end
                else
                begin
                    void'(value_queue.pop_front());
                end
            end
        end
    end

endmodule

`default_nettype wire

/* bench/gamma_curve_entry_generator_tb.sv */
// testbench top for the gamma curve entry generator: clock, reset, stimulus and verdict
// depends on gce_pkg, gamma_curve_entry_generator and gamma_curve_entry_generator_chk
`default_nettype none

module gamma_curve_entry_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [gce_pkg::IDX_W-1:0]   entry_index = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [gce_pkg::VAL_W-1:0]   curve_value;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic                        cfg_index = gce_pkg::CFG_GAMMA;
    logic [gce_pkg::CFG_W-1:0]   cfg_data = '0;

    int fail_count;
    int pending_count;
    int value_count;
    int request_count = 0;
    int write_count = 0;
    bit quiet = 1'b0;
    bit long_hold = 1'b0;
    int table_size = 256;

    gamma_curve_entry_generator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_value (curve_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    gamma_curve_entry_generator_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .entry_index   (entry_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .curve_value   (curve_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .value_count   (value_count)
    );

    always #10 clk = ~clk;

    // result side: random stalls, plus one long hold on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // one request, held until taken, then maybe an idle burst
    task automatic send_index(input logic [gce_pkg::IDX_W-1:0] idx);
        in_valid    <= 1'b1;
        entry_index <= idx;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        request_count++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // let every request finish, then allow for the pipeline depth
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (120) @(posedge clk);
    endtask

    // register write, only called when the block is idle
    task automatic write_reg(input logic which, input logic [gce_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        write_count++;
        if (which == gce_pkg::CFG_ENTRIES)
        begin
            table_size = (data[gce_pkg::ENT_W-1:0] < 2) ? 2 :
                         (data[gce_pkg::ENT_W-1:0] > 4096) ? 4096 :
                         int'(data[gce_pkg::ENT_W-1:0]);
        end
        @(posedge clk);
    endtask

    // random positions, mostly inside the table, some past its end
    task automatic random_batch(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_index(gce_pkg::IDX_W'($urandom_range(0, 4095)));
            else
                send_index(gce_pkg::IDX_W'($urandom_range(0, table_size - 1)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, ends, past the end
        send_index(12'd0);
        send_index(12'd1);
        send_index(12'd2);
        send_index(12'd127);
        send_index(12'd254);
        send_index(12'd255);
        send_index(12'd256);
        send_index(12'hFFF);
        send_index(12'h800);
        drain_pipe();

        // steepest curve with the largest table, reaching the zero case
        write_reg(gce_pkg::CFG_GAMMA, 16'd4915);
        write_reg(gce_pkg::CFG_ENTRIES, 16'd4096);
        send_index(12'd1);
        send_index(12'd2);
        send_index(12'd4094);
        send_index(12'd4095);
        send_index(12'd2048);
        drain_pipe();

        // saturating writes: all zeros and all ones
        write_reg(gce_pkg::CFG_GAMMA, 16'hFFFF);
        write_reg(gce_pkg::CFG_ENTRIES, 16'h0000);
        send_index(12'd0);
        send_index(12'd1);
        send_index(12'hFFF);
        drain_pipe();
        write_reg(gce_pkg::CFG_GAMMA, 16'h0000);
        write_reg(gce_pkg::CFG_ENTRIES, 16'hFFFF);
        send_index(12'd1);
        send_index(12'd3000);
        send_index(12'd4095);
        drain_pipe();

        // flattest legal curve, output held back long enough to fill the pipeline
        write_reg(gce_pkg::CFG_GAMMA, 16'd32768);
        write_reg(gce_pkg::CFG_ENTRIES, 16'd1024);
        long_hold = 1'b1;
        random_batch(120);
        drain_pipe();

        // random register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(gce_pkg::CFG_GAMMA, gce_pkg::CFG_W'($urandom_range(0, 65535)));
            write_reg(gce_pkg::CFG_ENTRIES, gce_pkg::CFG_W'($urandom_range(0, 8191)));
            random_batch(50);
            drain_pipe();
        end

        // last part without idling
        write_reg(gce_pkg::CFG_GAMMA, 16'd16384);
        write_reg(gce_pkg::CFG_ENTRIES, 16'd256);
        quiet = 1'b1;
        random_batch(60);
        drain_pipe();

        $display("tb: %0d requests, %0d results checked, %0d register writes",
                 request_count, value_count, write_count);
        $display("tb: covered gamma and table-size extremes, saturation and a full-pipeline stall");
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
